// ===== design/icfp_pkg.sv =====
// Shared types and constants for the motor command frame packer.
// No dependencies.
`default_nettype none
package icfp_pkg;

  localparam int LIM_W   = 31;
  localparam int VAL_W   = 32;
  localparam int ID_W    = 11;
  localparam int QBITS   = 16;            // quotient bits per divider lane
  localparam int DEN_W   = 32;            // span width
  localparam int NUM_W   = DEN_W + QBITS; // scaled offset width
  localparam int NLANES  = 5;
  localparam int SMALL_B = 12;

  localparam logic [1:0] KIND_CONTROL  = 2'd0;
  localparam logic [1:0] KIND_ENABLE   = 2'd1;
  localparam logic [1:0] KIND_DISABLE  = 2'd2;
  localparam logic [1:0] KIND_SET_ZERO = 2'd3;

  localparam logic [7:0] CMD_ENABLE   = 8'hFC;
  localparam logic [7:0] CMD_DISABLE  = 8'hFD;
  localparam logic [7:0] CMD_SET_ZERO = 8'hFE;
  localparam logic [55:0] MODE_PREFIX = {56{1'b1}};

  localparam logic [ID_W-1:0] MOTOR_A = 11'd1;
  localparam logic [ID_W-1:0] MOTOR_B = 11'd2;

  // register indexes
  localparam logic [2:0] REG_POS_A = 3'd0;
  localparam logic [2:0] REG_VEL_A = 3'd1;
  localparam logic [2:0] REG_TRQ_A = 3'd2;
  localparam logic [2:0] REG_POS_B = 3'd3;
  localparam logic [2:0] REG_VEL_B = 3'd4;
  localparam logic [2:0] REG_TRQ_B = 3'd5;
  localparam logic [2:0] REG_KP    = 3'd6;
  localparam logic [2:0] REG_KD    = 3'd7;

  // lane order in the frame
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_KP  = 2;
  localparam int LANE_KD  = 3;
  localparam int LANE_TRQ = 4;

  typedef logic [LIM_W-1:0] limit_t;

  typedef struct packed {
    limit_t pos_a;
    limit_t vel_a;
    limit_t trq_a;
    limit_t pos_b;
    limit_t vel_b;
    limit_t trq_b;
    limit_t kp;
    limit_t kd;
  } cfg_t;

  // one divide job: code = num / den
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lane_t;

  typedef struct packed {
    logic            is_mode;
    logic            err;
    logic [7:0]      cmd;
    logic [ID_W-1:0] id;
  } side_t;

  typedef struct packed {
    side_t                   side;
    lane_t [NLANES-1:0]      lanes;
  } item_t;

  // offset scaled by (2^bits - 1) as a shift and subtract
  function automatic logic [NUM_W-1:0] scale_off(input logic [DEN_W-1:0] off,
                                                 input logic wide);
    logic [NUM_W-1:0] o;
    begin
      o = {{QBITS{1'b0}}, off};
      scale_off = wide ? ((o << QBITS) - o) : ((o << SMALL_B) - o);
    end
  endfunction

  // clamp to [-lim, lim] and set up the divide
  function automatic lane_t prep_sym(input logic signed [VAL_W+1:0] x,
                                     input limit_t lim, input logic wide);
    logic signed [VAL_W+1:0] l;
    logic signed [VAL_W+1:0] xc;
    logic        [VAL_W+1:0] off;
    lane_t                   res;
    begin
      l = $signed({3'b000, lim});
      if (x > l) xc = l;
      else if (x < -l) xc = -l;
      else xc = x;
      off = $unsigned(xc + l);
      if (lim == '0) begin
        res.num = '0;
        res.den = 32'd1;
      end else begin
        res.num = scale_off(off[DEN_W-1:0], wide);
        res.den = {lim, 1'b0};
      end
      prep_sym = res;
    end
  endfunction

  // clamp to [0, lim] and set up the divide
  function automatic lane_t prep_gain(input logic signed [VAL_W-1:0] x,
                                      input limit_t lim);
    logic [DEN_W-1:0] off;
    lane_t            res;
    begin
      if (x < 0) off = '0;
      else if ($unsigned(x) > {1'b0, lim}) off = {1'b0, lim};
      else off = $unsigned(x);
      if (lim == '0) begin
        res.num = '0;
        res.den = 32'd1;
      end else begin
        res.num = scale_off(off, 1'b0);
        res.den = {1'b0, lim};
      end
      prep_gain = res;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/icfp_front.sv =====
// Front end: classifies a command and turns each quantity into a divide job.
// Depends on icfp_pkg.
`default_nettype none
module icfp_front (
  input  wire logic [1:0]                 kind,
  input  wire logic [icfp_pkg::ID_W-1:0]  node_id,
  input  wire logic [31:0]                pos,
  input  wire logic [31:0]                vel,
  input  wire logic [31:0]                kp,
  input  wire logic [31:0]                kd,
  input  wire logic [31:0]                trq,
  input  wire icfp_pkg::cfg_t             cfg,
  output icfp_pkg::item_t                 item
);
  import icfp_pkg::*;

  logic                    is_b;
  logic signed [VAL_W+1:0] pos_x, vel_x, trq_x;
  limit_t                  pl, vl, tl;

  // motor select and sign flip for the second motor
  always_comb begin
    is_b  = (node_id == MOTOR_B);
    pl    = is_b ? cfg.pos_b : cfg.pos_a;
    vl    = is_b ? cfg.vel_b : cfg.vel_a;
    tl    = is_b ? cfg.trq_b : cfg.trq_a;
    pos_x = {{2{pos[31]}}, pos};
    vel_x = {{2{vel[31]}}, vel};
    trq_x = {{2{trq[31]}}, trq};
    if (is_b) begin
      pos_x = -pos_x;
      vel_x = -vel_x;
      trq_x = -trq_x;
    end
  end

  // classify and build the divide jobs
  always_comb begin
    item.side.id      = node_id;
    item.side.is_mode = (kind != KIND_CONTROL);
    item.side.err     = (kind == KIND_CONTROL) && (node_id != MOTOR_A) && !is_b;
    case (kind)
      KIND_ENABLE:   item.side.cmd = CMD_ENABLE;
      KIND_DISABLE:  item.side.cmd = CMD_DISABLE;
      KIND_SET_ZERO: item.side.cmd = CMD_SET_ZERO;
      default:       item.side.cmd = CMD_ENABLE;
    endcase
    item.lanes[LANE_POS] = prep_sym(pos_x, pl, 1'b1);
    item.lanes[LANE_VEL] = prep_sym(vel_x, vl, 1'b0);
    item.lanes[LANE_KP]  = prep_gain(kp, cfg.kp);
    item.lanes[LANE_KD]  = prep_gain(kd, cfg.kd);
    item.lanes[LANE_TRQ] = prep_sym(trq_x, tl, 1'b0);
  end

endmodule
`default_nettype wire

// ===== design/icfp_queue.sv =====
// Two-word queue between the front end and the divider back end.
// Depends on icfp_pkg.
`default_nettype none
module icfp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire icfp_pkg::item_t wdata,
  input  wire logic            pop,
  output icfp_pkg::item_t      rdata,
  output logic                 not_empty,
  output logic                 full
);
  import icfp_pkg::*;

  item_t      mem [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (do_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/icfp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on icfp_pkg.
`default_nettype none
module icfp_div (
  input  wire logic                         clk,
  input  wire icfp_pkg::lane_t              job,
  output logic [icfp_pkg::QBITS-1:0]        quo
);
  import icfp_pkg::*;

  logic [DEN_W-1:0] rem_r [QBITS];
  logic [DEN_W-1:0] den_r [QBITS];
  logic [QBITS-1:0] low_r [QBITS];
  logic [QBITS-1:0] quo_r [QBITS];

  genvar s;
  generate
    for (s = 0; s < QBITS; s++) begin : g_stage
      logic [DEN_W-1:0] rem_in, den_in;
      logic [QBITS-1:0] low_in, quo_in;
      logic [DEN_W:0]   trial;
      logic             ge;
      if (s == 0) begin : g_first
        assign rem_in = job.num[NUM_W-1:QBITS];
        assign den_in = job.den;
        assign low_in = job.num[QBITS-1:0];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[s-1];
        assign den_in = den_r[s-1];
        assign low_in = low_r[s-1];
        assign quo_in = quo_r[s-1];
      end
      // shift in the next dividend bit, subtract if it fits
      assign trial = {rem_in, low_in[QBITS-1]};
      assign ge    = (trial >= {1'b0, den_in});
      always_ff @(posedge clk) begin
        rem_r[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den_r[s] <= den_in;
        low_r[s] <= {low_in[QBITS-2:0], 1'b0};
        quo_r[s] <= {quo_in[QBITS-2:0], ge};
      end
    end
  endgenerate

  assign quo = quo_r[QBITS-1];

endmodule
`default_nettype wire

// ===== design/icfp_back.sv =====
// Back end: five divider lanes, side data delay line and frame assembly.
// Depends on icfp_pkg and icfp_div.
`default_nettype none
module icfp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire icfp_pkg::item_t             item,
  output logic                             out_vld,
  output logic [63:0]                      out_frame,
  output logic [icfp_pkg::ID_W-1:0]        out_id,
  output logic                             out_err
);
  import icfp_pkg::*;

  logic [QBITS-1:0] code [NLANES];
  logic             vld_r  [QBITS];
  side_t            side_r [QBITS];
  logic             out_vld_r;
  logic [63:0]      frame_r;
  logic [ID_W-1:0]  id_r;
  logic             err_r;
  side_t            sd;
  logic [63:0]      frame_nxt;

  // divider lanes
  genvar l;
  generate
    for (l = 0; l < NLANES; l++) begin : g_lane
      icfp_div u_div (.clk(clk), .job(item.lanes[l]), .quo(code[l]));
    end
  endgenerate

  // side data travels beside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QBITS; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < QBITS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= item.side;
    for (int i = 1; i < QBITS; i++) side_r[i] <= side_r[i-1];
  end

  // frame assembly
  always_comb begin
    sd = side_r[QBITS-1];
    if (sd.is_mode) frame_nxt = {MODE_PREFIX, sd.cmd};
    else if (sd.err) frame_nxt = '0;
    else frame_nxt = {code[LANE_POS],
                      code[LANE_VEL][SMALL_B-1:0],
                      code[LANE_KP][SMALL_B-1:0],
                      code[LANE_KD][SMALL_B-1:0],
                      code[LANE_TRQ][SMALL_B-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[QBITS-1];
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    id_r    <= sd.id;
    err_r   <= sd.err && !sd.is_mode;
  end

  assign out_vld   = out_vld_r;
  assign out_frame = frame_r;
  assign out_id    = id_r;
  assign out_err   = err_r;

  // an error word carries an empty frame
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_err |-> out_frame == '0)
    else $error("error word with nonzero frame");

  // an enable mode word is never flagged
  a_mode_noerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_frame[63:8] == MODE_PREFIX && out_frame[7:0] == CMD_ENABLE
    |-> !out_err)
    else $error("mode word flagged as error");

  // output strobe only follows a valid in the delay line
  a_vld_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> $past(vld_r[QBITS-1]))
    else $error("output strobe without a job");

endmodule
`default_nettype wire

// ===== design/impedance_command_frame_packer.sv =====
// Top level: APB register file, front end, queue and divider back end.
// Depends on icfp_pkg, icfp_front, icfp_queue, icfp_back.
//
//  channel   handshake                 payload
//  input     start / busy              in_kind, in_node_id, in_target_*, in_*_gain, ...
//  result    out_strobe (no stall)     out_frame, out_can_id, out_error
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One command is taken every cycle while busy is low; each result passes through the
// queue stage, the 16-stage divider pipeline and the output stage before it is on
// the ports.
// Reset is synchronous, active low; it restores the limit registers and empties
// the pipeline. busy rises only if the two-word queue fills, which the
// non-stalling back end never allows.
`default_nettype none
module impedance_command_frame_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [10:0] in_node_id,
  input  wire logic [31:0] in_target_position,
  input  wire logic [31:0] in_target_velocity,
  input  wire logic [31:0] in_stiffness_gain,
  input  wire logic [31:0] in_damping_gain,
  input  wire logic [31:0] in_feedforward_torque,
  output logic             out_strobe,
  output logic [63:0]      out_frame,
  output logic [10:0]      out_can_id,
  output logic             out_error,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import icfp_pkg::*;

  localparam int LATENCY = QBITS + 2;

  cfg_t   cfg_r;
  item_t  f_item, q_item;
  logic   q_ne, q_full, acc, wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite && pready;
  assign acc     = start && !busy;
  assign busy    = q_full;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_a <= 31'd819200;
      cfg_r.vel_a <= 31'd3276800;
      cfg_r.trq_a <= 31'd1179648;
      cfg_r.pos_b <= 31'd819200;
      cfg_r.vel_b <= 31'd3276800;
      cfg_r.trq_b <= 31'd1179648;
      cfg_r.kp    <= 31'd32768000;
      cfg_r.kd    <= 31'd327680;
    end else if (wr) begin
      case (reg_idx)
        REG_POS_A: cfg_r.pos_a <= pwdata[LIM_W-1:0];
        REG_VEL_A: cfg_r.vel_a <= pwdata[LIM_W-1:0];
        REG_TRQ_A: cfg_r.trq_a <= pwdata[LIM_W-1:0];
        REG_POS_B: cfg_r.pos_b <= pwdata[LIM_W-1:0];
        REG_VEL_B: cfg_r.vel_b <= pwdata[LIM_W-1:0];
        REG_TRQ_B: cfg_r.trq_b <= pwdata[LIM_W-1:0];
        REG_KP:    cfg_r.kp    <= pwdata[LIM_W-1:0];
        REG_KD:    cfg_r.kd    <= pwdata[LIM_W-1:0];
        default:   cfg_r.kd    <= cfg_r.kd;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_POS_A: prdata = {1'b0, cfg_r.pos_a};
      REG_VEL_A: prdata = {1'b0, cfg_r.vel_a};
      REG_TRQ_A: prdata = {1'b0, cfg_r.trq_a};
      REG_POS_B: prdata = {1'b0, cfg_r.pos_b};
      REG_VEL_B: prdata = {1'b0, cfg_r.vel_b};
      REG_TRQ_B: prdata = {1'b0, cfg_r.trq_b};
      REG_KP:    prdata = {1'b0, cfg_r.kp};
      REG_KD:    prdata = {1'b0, cfg_r.kd};
      default:   prdata = '0;
    endcase
  end

  icfp_front u_front (
    .kind(in_kind), .node_id(in_node_id),
    .pos(in_target_position), .vel(in_target_velocity),
    .kp(in_stiffness_gain), .kd(in_damping_gain),
    .trq(in_feedforward_torque), .cfg(cfg_r), .item(f_item)
  );

  icfp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(acc), .wdata(f_item),
    .pop(1'b1), .rdata(q_item), .not_empty(q_ne), .full(q_full)
  );

  icfp_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(q_ne), .item(q_item),
    .out_vld(out_strobe), .out_frame(out_frame), .out_id(out_can_id),
    .out_err(out_error)
  );

  // every accepted command gives one result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LATENCY out_strobe)
    else $error("accepted command lost");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc, LATENCY))
    else $error("result without command");

  // the back end drains every cycle, so the queue never fills
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled");

endmodule
`default_nettype wire
